[design/stbl_pkg.sv]
// Shared types, codes and lamp tables of the sequential turn and brake lamp controller.
package stbl_pkg;

    // Signal mode codes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_LEFT  = 2'd1;
    localparam logic [1:0] MODE_RIGHT = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_BRAKE_ON_MAX   = 3'd0;
    localparam logic [2:0] REG_LEFT_MIN       = 3'd1;
    localparam logic [2:0] REG_RIGHT_ABOVE    = 3'd2;
    localparam logic [2:0] REG_SEQUENCE_START = 3'd3;
    localparam logic [2:0] REG_STEP_TICKS     = 3'd4;

    // Register reset values
    localparam logic [9:0] RST_BRAKE_ON_MAX   = 10'd588;
    localparam logic [9:0] RST_LEFT_MIN       = 10'd471;
    localparam logic [9:0] RST_RIGHT_ABOVE    = 10'd552;
    localparam logic [9:0] RST_SEQUENCE_START = 10'd250;
    localparam logic [7:0] RST_STEP_TICKS     = 8'd100;

    localparam int          CFG_IDX_W  = 3;
    localparam int          CFG_DATA_W = 10;
    localparam int          COUNT_W    = 11;
    localparam int          NUM_STEPS  = 5;
    localparam logic [7:0]  BRAKE_MASK = 8'hC3;

    // Fill patterns per step: left from the top lamp, right from the bottom lamp
    localparam logic [3:0] LEFT_FILL  [NUM_STEPS] = '{4'd0, 4'd8, 4'd12, 4'd14, 4'd15};
    localparam logic [3:0] RIGHT_FILL [NUM_STEPS] = '{4'd0, 4'd1, 4'd3, 4'd7, 4'd15};

    typedef struct packed {
        logic [9:0] brake_on_max;
        logic [9:0] left_min;
        logic [9:0] right_above;
        logic [9:0] sequence_start;
        logic [7:0] step_ticks;
    } t_cfg;

    typedef struct packed {
        logic [9:0] brake_sample;
        logic [9:0] switch_sample;
    } t_in;

    typedef struct packed {
        logic [7:0] lamp_pattern;
        logic [1:0] signal_mode;
    } t_out;

endpackage

[design/stbl_cfg.sv]
// Configuration register file of the lamp controller.
module stbl_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [stbl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stbl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output stbl_pkg::t_cfg                     o_cfg
);

    stbl_pkg::t_cfg r_cfg;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brake_on_max   <= stbl_pkg::RST_BRAKE_ON_MAX;
            r_cfg.left_min       <= stbl_pkg::RST_LEFT_MIN;
            r_cfg.right_above    <= stbl_pkg::RST_RIGHT_ABOVE;
            r_cfg.sequence_start <= stbl_pkg::RST_SEQUENCE_START;
            r_cfg.step_ticks     <= stbl_pkg::RST_STEP_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                stbl_pkg::REG_BRAKE_ON_MAX:   r_cfg.brake_on_max   <= i_cfg_data;
                stbl_pkg::REG_LEFT_MIN:       r_cfg.left_min       <= i_cfg_data;
                stbl_pkg::REG_RIGHT_ABOVE:    r_cfg.right_above    <= i_cfg_data;
                stbl_pkg::REG_SEQUENCE_START: r_cfg.sequence_start <= i_cfg_data;
                stbl_pkg::REG_STEP_TICKS:     r_cfg.step_ticks     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/stbl_seq.sv]
// Tick counter, turn lamp state and per-tick lamp byte logic.
module stbl_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stbl_pkg::t_cfg  i_cfg,
    input  logic            i_fire,
    input  stbl_pkg::t_in   i_item,
    output stbl_pkg::t_out  o_result
);

    logic [stbl_pkg::COUNT_W-1:0] r_tick_count, n_tick_count;
    logic [3:0]                   r_turn_lamps, n_turn_lamps;
    logic [1:0]                   mode;
    logic [7:0]                   brake_bits;
    logic [stbl_pkg::COUNT_W-1:0] step_at [stbl_pkg::NUM_STEPS];
    logic [stbl_pkg::COUNT_W-1:0] count_eff;

    // Step counts: start + k * step_ticks
    always_comb begin
        for (int k = 0; k < stbl_pkg::NUM_STEPS; k++) begin
            step_at[k] = stbl_pkg::COUNT_W'(i_cfg.sequence_start)
                       + stbl_pkg::COUNT_W'(k) * stbl_pkg::COUNT_W'(i_cfg.step_ticks);
        end
    end

    // Classify switch, brake bits, lamp update and counter advance
    always_comb begin
        if (i_item.switch_sample > i_cfg.right_above) begin
            mode = stbl_pkg::MODE_RIGHT;
        end else if (i_item.switch_sample >= i_cfg.left_min) begin
            mode = stbl_pkg::MODE_LEFT;
        end else begin
            mode = stbl_pkg::MODE_OFF;
        end

        brake_bits = (i_item.brake_sample <= i_cfg.brake_on_max) ? stbl_pkg::BRAKE_MASK : 8'd0;

        n_turn_lamps = r_turn_lamps;
        count_eff    = r_tick_count;
        if (mode == stbl_pkg::MODE_OFF) begin
            n_turn_lamps = 4'd0;
            count_eff    = '0;
        end else begin
            // later step wins when step counts coincide
            for (int k = 0; k < stbl_pkg::NUM_STEPS; k++) begin
                if (r_tick_count == step_at[k]) begin
                    n_turn_lamps = (mode == stbl_pkg::MODE_LEFT) ?
                                   stbl_pkg::LEFT_FILL[k] : stbl_pkg::RIGHT_FILL[k];
                end
            end
        end

        // wrap past the last step, then count this tick
        if (count_eff > step_at[stbl_pkg::NUM_STEPS-1]) begin
            count_eff = '0;
        end
        n_tick_count = count_eff + stbl_pkg::COUNT_W'(1);

        o_result.lamp_pattern = brake_bits | {2'b00, n_turn_lamps, 2'b00};
        o_result.signal_mode  = mode;
    end

    // State advances once per transfer through this stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_turn_lamps <= 4'd0;
        end else if (i_fire) begin
            r_tick_count <= n_tick_count;
            r_turn_lamps <= n_turn_lamps;
        end
    end

endmodule

[design/sequential_turn_brake_lamp_control_top.sv]
// Top level of the sequential turn and brake lamp controller.
//
//  channel | direction | payload            | handshake
//  in      | input     | t_in  (two samples)| i_in_valid / o_in_stall
//  out     | output    | t_out (lamps, mode)| o_out_valid / i_out_stall
//  cfg     | input     | 10-bit data        | i_cfg_we, i_cfg_index
//
// One tick per cycle while the result is not stalled; a tick passes the input register, then the result register.
// The tick counter and turn lamp state update as an item moves into the result register.
// Reset is synchronous, active low; it clears valids and state and sets the configuration registers to defaults.
// A stalled result holds the result register; a full input register then holds and stalls in.
module sequential_turn_brake_lamp_control_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  stbl_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output stbl_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [stbl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stbl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    stbl_pkg::t_cfg cfg;
    stbl_pkg::t_in  r_in_data;
    logic           r_in_valid;
    stbl_pkg::t_out r_out_data;
    logic           r_out_valid;
    stbl_pkg::t_out result;
    logic           out_free;
    logic           fire;

    stbl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    stbl_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_item   (r_in_data),
        .o_result (result)
    );

    // Pipeline flow control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[test/sequential_turn_brake_lamp_control_top_test.sv]
// Self-checking testbench for the sequential turn and brake lamp controller.
import stbl_pkg::*;

// Scoreboard: predicts the lamp byte and signal mode for each accepted tick and checks results in order
class lamp_scoreboard;
    logic [9:0]  brake_on_max;
    logic [9:0]  left_min;
    logic [9:0]  right_above;
    logic [9:0]  seq_start;
    logic [7:0]  step_ticks;
    logic [10:0] tick_count;
    logic [3:0]  turn_lamps;
    t_out        lamps_due[$];
    int          mismatches;
    int          ticks_in;
    int          results_seen;

    function new();
        brake_on_max = RST_BRAKE_ON_MAX;
        left_min     = RST_LEFT_MIN;
        right_above  = RST_RIGHT_ABOVE;
        seq_start    = RST_SEQUENCE_START;
        step_ticks   = RST_STEP_TICKS;
        tick_count   = '0;
        turn_lamps   = '0;
        mismatches   = 0;
        ticks_in     = 0;
        results_seen = 0;
    endfunction

    // Register write as seen by the block; unused indexes change nothing
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_BRAKE_ON_MAX:   brake_on_max = value;
            REG_LEFT_MIN:       left_min     = value;
            REG_RIGHT_ABOVE:    right_above  = value;
            REG_SEQUENCE_START: seq_start    = value;
            REG_STEP_TICKS:     step_ticks   = value[7:0];
            default: ;
        endcase
    endfunction

    // One tick: classify, brake bits, turn lamp update, counter wrap and increment
    function t_out next_lamps(t_in tick);
        t_out       res;
        logic [1:0] mode;
        logic [7:0] brake_bits;
        int         count;
        int         last;
        count = tick_count;
        if (tick.switch_sample > right_above) begin
            mode = MODE_RIGHT;
        end else if (tick.switch_sample >= left_min) begin
            mode = MODE_LEFT;
        end else begin
            mode = MODE_OFF;
        end
        brake_bits = (tick.brake_sample <= brake_on_max) ? BRAKE_MASK : 8'h00;
        if (mode == MODE_OFF) begin
            turn_lamps = '0;
            count      = 0;
        end else begin
            // later steps win where step counts coincide
            for (int k = 0; k < NUM_STEPS; k++) begin
                if (count == int'(seq_start) + k * int'(step_ticks)) begin
                    if (mode == MODE_LEFT) turn_lamps = ~(4'hF >> k);
                    else                   turn_lamps = 4'hF >> (4 - k);
                end
            end
        end
        last = int'(seq_start) + 4 * int'(step_ticks);
        if (count > last) count = 0;
        count      = (count + 1) & 32'h7FF;
        tick_count = count[10:0];
        res.lamp_pattern = brake_bits | {2'b00, turn_lamps, 2'b00};
        res.signal_mode  = mode;
        return res;
    endfunction

    function void note_tick(t_in tick);
        lamps_due.push_back(next_lamps(tick));
        ticks_in++;
    endfunction

    task check_lamps(t_out got);
        t_out want;
        results_seen++;
        if (lamps_due.size() == 0) begin
            report("result with no tick outstanding", 8'h00, got.lamp_pattern);
            return;
        end
        want = lamps_due.pop_front();
        if (got.lamp_pattern !== want.lamp_pattern)
            report("lamp_pattern", want.lamp_pattern, got.lamp_pattern);
        if (got.signal_mode !== want.signal_mode)
            report("signal_mode", {6'b0, want.signal_mode}, {6'b0, got.signal_mode});
    endtask

    // One line per mismatch
    task report(string what, logic [7:0] want, logic [7:0] got);
        mismatches++;
        $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
    endtask
endclass

module sequential_turn_brake_lamp_control_top_test;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_TICKS = 220;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out                  o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lamp_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             idle_cycles;
    int             settings_run;
    bit             hold_req;

    sequential_turn_brake_lamp_control_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, and one long hold-off when asked for
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Monitor: log input transfers, check output transfers, watchdog
    always @(posedge i_clk) begin
        logic in_xfer;
        logic out_xfer;
        in_xfer  = i_in_valid && !o_in_stall;
        out_xfer = o_out_valid && !i_out_stall;
        if (i_rst_n) begin
            if (in_xfer) sb.note_tick(i_in_data);
            if (out_xfer) sb.check_lamps(o_out_data);
            if (in_xfer || out_xfer) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: %0d cycles without a transfer", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic t_in make_tick(int brake, int sw);
        t_in tick;
        tick.brake_sample  = brake[9:0];
        tick.switch_sample = sw[9:0];
        return tick;
    endfunction

    function automatic t_cfg make_cfg(int brake, int left, int right, int start, int step);
        t_cfg c;
        c.brake_on_max   = brake[9:0];
        c.left_min       = left[9:0];
        c.right_above    = right[9:0];
        c.sequence_start = start[9:0];
        c.step_ticks     = step[7:0];
        return c;
    endfunction

    // Switch value inside the band of the wanted mode, edges favoured; any value if the band is empty
    function automatic int pick_switch(logic [1:0] mode, t_cfg c);
        int lo;
        int hi;
        int r;
        case (mode)
            MODE_RIGHT: begin
                lo = int'(c.right_above) + 1;
                hi = 1023;
            end
            MODE_LEFT: begin
                lo = int'(c.left_min);
                hi = int'(c.right_above);
            end
            default: begin
                lo = 0;
                hi = ((int'(c.left_min) < int'(c.right_above) + 1) ?
                      int'(c.left_min) : int'(c.right_above) + 1) - 1;
            end
        endcase
        if (lo > hi) return $urandom_range(1023);
        r = $urandom_range(99);
        if (r < 12) return lo;
        if (r < 24) return hi;
        return $urandom_range(hi, lo);
    endfunction

    function automatic int pick_brake(t_cfg c);
        int b;
        if ($urandom_range(99) < 70) return $urandom_range(1023);
        b = int'(c.brake_on_max) + int'($urandom_range(2)) - 1;
        if (b < 0) b = 0;
        if (b > 1023) b = 1023;
        return b;
    endfunction

    // Offer one tick, with random gaps first, and wait for its transfer
    task automatic send_tick(t_in tick);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= tick;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drain: every expected result back, then let the pipeline settle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.lamps_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    // Write every register, plus junk to the unused indexes
    task automatic load_settings(t_cfg c);
        logic [1:0] junk;
        junk = 2'($urandom_range(3));
        i_cfg_we <= 1'b1;
        put_reg(REG_BRAKE_ON_MAX, c.brake_on_max);
        put_reg(REG_LEFT_MIN, c.left_min);
        put_reg(REG_RIGHT_ABOVE, c.right_above);
        put_reg(REG_SEQUENCE_START, c.sequence_start);
        put_reg(REG_STEP_TICKS, {junk, c.step_ticks});
        for (int j = REG_STEP_TICKS + 1; j < 2 ** CFG_IDX_W; j++)
            put_reg(j[CFG_IDX_W-1:0], CFG_DATA_W'($urandom_range(1023)));
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Random phase: mostly held switch positions, runs of up to min(last + 10, 400) ticks
    task automatic run_phase(t_cfg c, int send_pct, int recv_pct, bit long_hold);
        int         run_left;
        int         last;
        int         roll;
        logic [1:0] mode;
        t_in        tick;
        settle();
        load_settings(c);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        hold_req       = long_hold;
        last     = int'(c.sequence_start) + 4 * int'(c.step_ticks);
        run_left = 0;
        mode     = MODE_OFF;
        for (int i = 0; i < PHASE_TICKS; i++) begin
            if (run_left == 0) begin
                roll = $urandom_range(99);
                mode = (roll < 12) ? MODE_OFF : (roll < 56) ? MODE_LEFT : MODE_RIGHT;
                if (mode == MODE_OFF) run_left = $urandom_range(4, 1);
                else run_left = $urandom_range((last + 10 > 400) ? 400 : last + 10, 1);
            end
            run_left--;
            if ($urandom_range(99) < 12)
                tick = make_tick($urandom_range(1023), $urandom_range(1023));
            else
                tick = make_tick(pick_brake(c), pick_switch(mode, c));
            send_tick(tick);
        end
    endtask

    // Main sequence
    initial begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        idle_cycles    = 0;
        settings_run   = 1;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes and threshold edges at the reset settings
        send_tick(make_tick(0, 0));
        send_tick(make_tick(1023, 1023));
        send_tick(make_tick(588, 470));
        send_tick(make_tick(589, 471));
        send_tick(make_tick(588, 552));
        send_tick(make_tick(1023, 553));
        send_tick(make_tick(10'h2AA, 10'h155));
        send_tick(make_tick(10'h155, 10'h2AA));

        // zero step and zero start: all steps coincide at a count the counter no longer reaches
        settle();
        load_settings(make_cfg(588, 471, 552, 0, 0));
        send_tick(make_tick(100, 500));
        send_tick(make_tick(900, 500));
        send_tick(make_tick(100, 0));
        send_tick(make_tick(100, 900));
        send_tick(make_tick(700, 900));

        // thresholds crossed over: right is tested first
        settle();
        load_settings(make_cfg(588, 700, 300, 1, 1));
        send_tick(make_tick(0, 500));
        send_tick(make_tick(0, 200));
        send_tick(make_tick(0, 300));
        send_tick(make_tick(0, 301));

        // short sequence: left fills lamp by lamp and wraps
        settle();
        load_settings(make_cfg(588, 471, 552, 1, 1));
        for (int i = 0; i < 8; i++) send_tick(make_tick(600, 500));

        // random phases over several settings and idling patterns
        run_phase(make_cfg(588, 471, 552, 3, 2), 0, 0, 1'b0);
        run_phase(make_cfg(1023, 0, 1023, 1, 1), 65, 0, 1'b0);
        run_phase(make_cfg(0, 1023, 0, 10, 5), 0, 65, 1'b1);
        run_phase(make_cfg(300, 200, 800, 40, 20), 13, 13, 1'b0);
        run_phase(make_cfg(588, 471, 552, 0, 0), 0, 0, 1'b0);
        run_phase(make_cfg(512, 400, 600, 1023, 255), 65, 0, 1'b1);
        run_phase(make_cfg(700, 300, 700, 2, 30), 0, 65, 1'b0);
        run_phase(make_cfg(588, 471, 552, 20, 10), 13, 13, 1'b0);

        settle();
        repeat (4) @(posedge i_clk);
        $display("Checked %0d lamp results from %0d ticks over %0d register settings,",
                 sb.results_seen, sb.ticks_in, settings_run);
        $display("with sender gaps, receiver stalls and a long hold-off; %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

[files.f]
design/stbl_pkg.sv
design/stbl_cfg.sv
design/stbl_seq.sv
design/sequential_turn_brake_lamp_control_top.sv
test/sequential_turn_brake_lamp_control_top_test.sv
